[hw/rtl/ste_pkg.sv]
package ste_pkg;

	localparam int NUM_SLOTS = 8;
	localparam int IDX_W     = $clog2(NUM_SLOTS);
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 2;
	localparam int TOKEN_W   = 64;
	localparam int USER_W    = 22;
	localparam int TIME_W    = 32;

	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1800000;

	localparam logic [OP_W-1:0] OP_OPEN  = 2'd0;
	localparam logic [OP_W-1:0] OP_CLOSE = 2'd1;
	localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EXPIRED   = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [TOKEN_W-1:0] token_high;
		logic [TOKEN_W-1:0] token_low;
		logic [USER_W-1:0]  user;
		logic [TIME_W-1:0]  created;
		logic [TIME_W-1:0]  last_used;
	} slot_t;

endpackage

[hw/rtl/ste_slot_mem.sv]
module ste_slot_mem (
	input  logic          clk,
	input  logic          wr_en,
	input  ste_pkg::idx_t wr_addr,
	input  ste_pkg::slot_t wr_data,
	input  logic          rd_en,
	input  ste_pkg::idx_t rd_addr,
	output ste_pkg::slot_t rd_data
);

	ste_pkg::slot_t mem [ste_pkg::NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/session_table_with_expiry_top.sv]
// Session table: eight slots, each holding a 128-bit token, a user id, a
// creation time, a last-use time and an active bit.
// Command channel: drive opcode, token_high/low, user_id and now_ms with
// start; the command is taken at an edge where start is high and busy low.
// Result channel: done pulses for one cycle with status, slot_index,
// user_id_out and evicted; the receiver must take the word in that cycle.
// Config channel: cfg_data is written to the idle timeout when cfg_valid is
// high; cfg_ready is always high. Write it only while the block is idle.
// Timing: an open that finds a free slot, and an unused opcode, answer in the
// cycle after the command. Any other command scans the slot memory one slot
// per cycle through its single registered read port: an open that must evict
// reads every slot, a close or check stops at the slot where the token matches
// or at the last slot. One command is in flight at a time.
// Reset clears every active bit and loads the timeout with 1800000 ms; the
// slot memory contents are not cleared, since inactive slots are never read
// for a result. No clearing pass is needed.
module session_table_with_expiry_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [ste_pkg::OP_W-1:0]            opcode,
	input  logic [ste_pkg::TOKEN_W-1:0]         token_high,
	input  logic [ste_pkg::TOKEN_W-1:0]         token_low,
	input  logic [ste_pkg::USER_W-1:0]          user_id,
	input  logic [ste_pkg::TIME_W-1:0]          now_ms,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ste_pkg::TIME_W-1:0]          cfg_data,
	output logic                                done,
	output logic [ste_pkg::STATUS_W-1:0]        status,
	output logic [ste_pkg::IDX_W-1:0]           slot_index,
	output logic [ste_pkg::USER_W-1:0]          user_id_out,
	output logic                                evicted
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	localparam ste_pkg::idx_t LAST_IDX = ste_pkg::IDX_W'(ste_pkg::NUM_SLOTS - 1);

	state_t state_q, state_d;

	logic [ste_pkg::NUM_SLOTS-1:0] active_q;
	logic [ste_pkg::TIME_W-1:0]    timeout_q;

	logic [ste_pkg::OP_W-1:0]      op_q;
	logic [ste_pkg::TOKEN_W-1:0]   tok_high_q;
	logic [ste_pkg::TOKEN_W-1:0]   tok_low_q;
	logic [ste_pkg::USER_W-1:0]    user_q;
	logic [ste_pkg::TIME_W-1:0]    now_q;

	logic           issue_q;
	ste_pkg::idx_t  ptr_q;
	logic           rd_vld_s1;
	ste_pkg::idx_t  rd_idx_s1;
	ste_pkg::slot_t rd_data;

	ste_pkg::idx_t              min_idx_q;
	logic [ste_pkg::TIME_W-1:0] min_created_q;
	logic                       cand_take;
	ste_pkg::idx_t              cand_idx;

	logic                       any_free;
	ste_pkg::idx_t              free_idx;
	logic                       hit;
	logic                       last_s1;
	logic [ste_pkg::TIME_W-1:0] elapsed;
	ste_pkg::slot_t             refresh_word;

	logic           wr_en;
	ste_pkg::idx_t  wr_addr;
	ste_pkg::slot_t wr_data;
	logic           set_en;
	logic           clr_en;

	logic                          res_fire;
	logic [ste_pkg::STATUS_W-1:0]  res_status;
	ste_pkg::idx_t                 res_idx;
	logic [ste_pkg::USER_W-1:0]    res_user;
	logic                          res_ev;

	logic                          done_q;
	logic [ste_pkg::STATUS_W-1:0]  status_q;
	ste_pkg::idx_t                 idx_q;
	logic [ste_pkg::USER_W-1:0]    user_out_q;
	logic                          ev_q;

	ste_slot_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue_q),
		.rd_addr (ptr_q),
		.rd_data (rd_data)
	);

	assign busy        = (state_q != S_IDLE);
	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign status      = status_q;
	assign slot_index  = idx_q;
	assign user_id_out = user_out_q;
	assign evicted     = ev_q;

	// lowest inactive slot
	always_comb begin
		free_idx = '0;
		for (int i = ste_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_idx = ste_pkg::IDX_W'(i);
			end
		end
	end

	assign any_free = ~&active_q;
	assign last_s1  = (rd_idx_s1 == LAST_IDX);
	assign hit      = active_q[rd_idx_s1] && (rd_data.token_high == tok_high_q) &&
	                  (rd_data.token_low == tok_low_q);
	assign elapsed  = now_q - rd_data.last_used;

	// strict less keeps the lowest index on a tie
	assign cand_take = (rd_idx_s1 == '0) || (rd_data.created < min_created_q);
	assign cand_idx  = cand_take ? rd_idx_s1 : min_idx_q;

	always_comb begin
		refresh_word           = rd_data;
		refresh_word.last_used = now_q;
	end

	always_comb begin
		state_d    = state_q;
		wr_en      = 1'b0;
		wr_addr    = free_idx;
		wr_data    = '{token_high, token_low, user_id, now_ms, now_ms};
		set_en     = 1'b0;
		clr_en     = 1'b0;
		res_fire   = 1'b0;
		res_status = ste_pkg::ST_NOT_FOUND;
		res_idx    = '0;
		res_user   = '0;
		res_ev     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (opcode == ste_pkg::OP_OPEN && any_free) begin
						wr_en      = 1'b1;
						set_en     = 1'b1;
						res_fire   = 1'b1;
						res_status = ste_pkg::ST_OK;
						res_idx    = free_idx;
						res_user   = user_id;
					end else if (opcode == ste_pkg::OP_OPEN || opcode == ste_pkg::OP_CLOSE ||
					             opcode == ste_pkg::OP_CHECK) begin
						state_d = S_SCAN;
					end else begin
						res_fire = 1'b1;
					end
				end
			end
			S_SCAN: begin
				if (rd_vld_s1) begin
					if (op_q == ste_pkg::OP_OPEN) begin
						if (last_s1) begin
							wr_en      = 1'b1;
							wr_addr    = cand_idx;
							wr_data    = '{tok_high_q, tok_low_q, user_q, now_q, now_q};
							set_en     = 1'b1;
							res_fire   = 1'b1;
							res_status = ste_pkg::ST_OK;
							res_idx    = cand_idx;
							res_user   = user_q;
							res_ev     = 1'b1;
							state_d    = S_IDLE;
						end
					end else if (hit) begin
						res_fire = 1'b1;
						res_idx  = rd_idx_s1;
						res_user = rd_data.user;
						state_d  = S_IDLE;
						if (op_q == ste_pkg::OP_CLOSE) begin
							clr_en     = 1'b1;
							res_status = ste_pkg::ST_OK;
						end else if (elapsed > timeout_q) begin
							clr_en     = 1'b1;
							res_status = ste_pkg::ST_EXPIRED;
						end else begin
							wr_en      = 1'b1;
							wr_addr    = rd_idx_s1;
							wr_data    = refresh_word;
							res_status = ste_pkg::ST_OK;
						end
					end else if (last_s1) begin
						res_fire = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			active_q  <= '0;
			timeout_q <= ste_pkg::TIMEOUT_RESET;
			issue_q   <= 1'b0;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_fire;
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
			if (set_en) begin
				active_q[wr_addr] <= 1'b1;
			end
			if (clr_en) begin
				active_q[rd_idx_s1] <= 1'b0;
			end
			rd_vld_s1 <= (state_q == S_SCAN) && issue_q && (state_d == S_SCAN);
			if (state_q == S_IDLE && state_d == S_SCAN) begin
				issue_q <= 1'b1;
				ptr_q   <= '0;
			end else if (state_d == S_IDLE) begin
				issue_q <= 1'b0;
			end else if (issue_q) begin
				// stop issuing after the last slot
				if (ptr_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q       <= opcode;
			tok_high_q <= token_high;
			tok_low_q  <= token_low;
			user_q     <= user_id;
			now_q      <= now_ms;
		end
		rd_idx_s1 <= ptr_q;
		if (rd_vld_s1) begin
			min_idx_q     <= cand_idx;
			min_created_q <= cand_take ? rd_data.created : min_created_q;
		end
		if (res_fire) begin
			status_q   <= res_status;
			idx_q      <= res_idx;
			user_out_q <= res_user;
			ev_q       <= res_ev;
		end
	end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

typedef struct packed {
	logic [ste_pkg::STATUS_W-1:0] status;
	ste_pkg::idx_t                slot;
	logic [ste_pkg::USER_W-1:0]   user;
	logic                         evicted;
} session_reply_t;

class session_mirror;
	logic [ste_pkg::TOKEN_W-1:0] tok_hi     [ste_pkg::NUM_SLOTS];
	logic [ste_pkg::TOKEN_W-1:0] tok_lo     [ste_pkg::NUM_SLOTS];
	logic [ste_pkg::USER_W-1:0]  owner      [ste_pkg::NUM_SLOTS];
	logic [ste_pkg::TIME_W-1:0]  created    [ste_pkg::NUM_SLOTS];
	logic [ste_pkg::TIME_W-1:0]  last_used  [ste_pkg::NUM_SLOTS];
	bit                          live       [ste_pkg::NUM_SLOTS];
	logic [ste_pkg::TIME_W-1:0]  idle_limit;
	session_reply_t              replies_due[$];
	int mismatches, replies_seen;
	int n_open, n_evict, n_close, n_live, n_expired, n_miss;

	function new();
		for (int i = 0; i < ste_pkg::NUM_SLOTS; i++) begin
			tok_hi[i] = '0;
			tok_lo[i] = '0;
			owner[i] = '0;
			created[i] = '0;
			last_used[i] = '0;
			live[i] = 1'b0;
		end
		idle_limit = ste_pkg::TIMEOUT_RESET;
	endfunction

	function void set_timeout(logic [ste_pkg::TIME_W-1:0] v);
		idle_limit = v;
	endfunction

	function int pending();
		return replies_due.size();
	endfunction

	function void note_command(logic [ste_pkg::OP_W-1:0] op, logic [ste_pkg::TOKEN_W-1:0] th,
	                           logic [ste_pkg::TOKEN_W-1:0] tl,
	                           logic [ste_pkg::USER_W-1:0] user,
	                           logic [ste_pkg::TIME_W-1:0] now);
		session_reply_t r;
		int slot, oldest, hit;
		logic [ste_pkg::TIME_W-1:0] idle_ms;
		r = '0;
		r.status = ste_pkg::ST_NOT_FOUND;
		if (op == ste_pkg::OP_OPEN) begin
			slot = -1;
			oldest = 0;
			// lowest free slot; track the oldest live one until a free one turns up
			for (int i = 0; i < ste_pkg::NUM_SLOTS; i++) begin
				if (slot < 0) begin
					if (!live[i])
						slot = i;
					else if (created[i] < created[oldest])
						oldest = i;
				end
			end
			if (slot < 0) begin
				slot = oldest;
				r.evicted = 1'b1;
				n_evict++;
			end
			tok_hi[slot] = th;
			tok_lo[slot] = tl;
			owner[slot] = user;
			created[slot] = now;
			last_used[slot] = now;
			live[slot] = 1'b1;
			r.status = ste_pkg::ST_OK;
			r.slot = ste_pkg::idx_t'(slot);
			r.user = user;
			n_open++;
		end else if (op == ste_pkg::OP_CLOSE || op == ste_pkg::OP_CHECK) begin
			hit = -1;
			for (int i = ste_pkg::NUM_SLOTS - 1; i >= 0; i--)
				if (live[i] && tok_hi[i] == th && tok_lo[i] == tl)
					hit = i;
			if (hit < 0) begin
				n_miss++;
			end else begin
				r.slot = ste_pkg::idx_t'(hit);
				r.user = owner[hit];
				idle_ms = now - last_used[hit];
				if (op == ste_pkg::OP_CLOSE) begin
					live[hit] = 1'b0;
					r.status = ste_pkg::ST_OK;
					n_close++;
				end else if (idle_ms > idle_limit) begin
					live[hit] = 1'b0;
					r.status = ste_pkg::ST_EXPIRED;
					n_expired++;
				end else begin
					last_used[hit] = now;
					r.status = ste_pkg::ST_OK;
					n_live++;
				end
			end
		end else begin
			n_miss++;
		end
		replies_due.push_back(r);
	endfunction

	function void check_reply(logic [ste_pkg::STATUS_W-1:0] status, ste_pkg::idx_t slot,
	                          logic [ste_pkg::USER_W-1:0] user, logic evicted);
		session_reply_t want;
		replies_seen++;
		if (replies_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: reply word with nothing outstanding: ",
				         "status %0d slot %0d user %h evicted %0d",
				         $realtime, status, slot, user, evicted);
		end else begin
			want = replies_due.pop_front();
			if (want.status !== status || want.slot !== slot || want.user !== user ||
			    want.evicted !== evicted) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: reply mismatch: ", $realtime,
					         "expected status %0d slot %0d user %h evicted %0d, ",
					         want.status, want.slot, want.user, want.evicted,
					         "got status %0d slot %0d user %h evicted %0d",
					         status, slot, user, evicted);
			end
		end
	endfunction
endclass

module tb;

	localparam logic [ste_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 12;
	localparam int STALL_LIMIT   = 2000;
	localparam int PHASE_ITEMS   = 100;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic                         busy;
	logic [ste_pkg::OP_W-1:0]     opcode = '0;
	logic [ste_pkg::TOKEN_W-1:0]  token_high = '0;
	logic [ste_pkg::TOKEN_W-1:0]  token_low = '0;
	logic [ste_pkg::USER_W-1:0]   user_id = '0;
	logic [ste_pkg::TIME_W-1:0]   now_ms = '0;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [ste_pkg::TIME_W-1:0]   cfg_data = '0;
	logic                         done;
	logic [ste_pkg::STATUS_W-1:0] status;
	ste_pkg::idx_t                slot_index;
	logic [ste_pkg::USER_W-1:0]   user_id_out;
	logic                         evicted;

	session_mirror mirror = new();

	logic [ste_pkg::TIME_W-1:0]  now_clock;
	logic [ste_pkg::TIME_W-1:0]  timeout_now = ste_pkg::TIMEOUT_RESET;
	logic [ste_pkg::TOKEN_W-1:0] known_hi[$];
	logic [ste_pkg::TOKEN_W-1:0] known_lo[$];
	int n_sent = 0;
	int n_settings = 0;
	int quiet_cycles = 0;

	session_table_with_expiry_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.token_high  (token_high),
		.token_low   (token_low),
		.user_id     (user_id),
		.now_ms      (now_ms),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.status      (status),
		.slot_index  (slot_index),
		.user_id_out (user_id_out),
		.evicted     (evicted)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				mirror.check_reply(status, slot_index, user_id_out, evicted);
			if (start && !busy)
				mirror.note_command(opcode, token_high, token_low, user_id, now_ms);
			if (cfg_valid && cfg_ready)
				mirror.set_timeout(cfg_data);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("no handshake for %0d cycles, giving up", STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_cmd(input logic [ste_pkg::OP_W-1:0] op,
	                        input logic [ste_pkg::TOKEN_W-1:0] th,
	                        input logic [ste_pkg::TOKEN_W-1:0] tl,
	                        input logic [ste_pkg::USER_W-1:0] user,
	                        input logic [ste_pkg::TIME_W-1:0] now);
		start <= 1'b1;
		opcode <= op;
		token_high <= th;
		token_low <= tl;
		user_id <= user;
		now_ms <= now;
		do @(posedge clk); while (busy);
		n_sent++;
	endtask

	task automatic gap(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// hold off until every reply word is back, then let the block go quiet
	task automatic settle();
		start <= 1'b0;
		do @(negedge clk); while (mirror.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [ste_pkg::TIME_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		timeout_now = v;
		n_settings++;
	endtask

	function automatic logic [ste_pkg::TOKEN_W-1:0] rand_half();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return '0;
		else if (roll < 16)
			return '1;
		return {$urandom, $urandom};
	endfunction

	task automatic random_cmd(input bit calm);
		int roll, pick;
		logic [ste_pkg::OP_W-1:0]    op;
		logic [ste_pkg::TOKEN_W-1:0] th, tl;
		logic [ste_pkg::TIME_W-1:0]  step;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			op = ste_pkg::OP_OPEN;
		else if (roll < 52)
			op = ste_pkg::OP_CLOSE;
		else if (roll < 97)
			op = ste_pkg::OP_CHECK;
		else
			op = OP_UNUSED;
		th = rand_half();
		tl = rand_half();
		roll = $urandom_range(0, 99);
		if (known_hi.size() != 0) begin
			pick = $urandom_range(0, known_hi.size() - 1);
			// reuse a token: duplicates on open, otherwise mostly recent tokens, some with a bit flipped
			if ((op == ste_pkg::OP_OPEN && roll < 15) ||
			    (op != ste_pkg::OP_OPEN && roll < 85)) begin
				th = known_hi[pick];
				tl = known_lo[pick];
				if (op != ste_pkg::OP_OPEN && roll >= 75) begin
					if ($urandom_range(0, 1))
						th[$urandom_range(0, ste_pkg::TOKEN_W - 1)] ^= 1'b1;
					else
						tl[$urandom_range(0, ste_pkg::TOKEN_W - 1)] ^= 1'b1;
				end
			end
		end
		if (op == ste_pkg::OP_OPEN) begin
			known_hi.push_back(th);
			known_lo.push_back(tl);
			if (known_hi.size() > 12) begin
				void'(known_hi.pop_front());
				void'(known_lo.pop_front());
			end
		end
		// advance time by small steps, steps on the scale of the current timeout, or random jumps
		roll = $urandom_range(0, 99);
		if (roll < 35)
			step = $urandom_range(0, 3);
		else if (roll < 65)
			step = $urandom_range(0, timeout_now / 8 + 1);
		else if (roll < 90)
			step = $urandom_range(timeout_now / 2, timeout_now);
		else if (roll < 95)
			step = $urandom;
		else begin
			step = 0;
			now_clock = $urandom;
		end
		now_clock = now_clock + step;
		send_cmd(op, th, tl, ste_pkg::USER_W'($urandom), now_clock);
		if (!calm) begin
			if ($urandom_range(0, 99) < 30)
				gap($urandom_range(1, 9));
			if ($urandom_range(0, 199) == 0)
				settle();
		end
	endtask

	initial begin
		logic [ste_pkg::TOKEN_W-1:0] ah, al, bh, bl, ch, cl;
		logic [ste_pkg::TIME_W-1:0]  phase_timeout [8];
		ah = '0;
		al = '0;
		bh = '1;
		bl = '1;
		ch = 64'h0123_4567_89AB_CDEF;
		cl = 64'hFEDC_BA98_7654_3210;
		phase_timeout = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1000, ste_pkg::TIMEOUT_RESET,
		                  32'h8000_0000, $urandom_range(2, 5000), $urandom};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty table, unused opcode
		send_cmd(ste_pkg::OP_CHECK, ah, al, 22'h155555, 32'd0);
		send_cmd(ste_pkg::OP_CLOSE, bh, bl, 22'h3FFFFF, 32'd0);
		gap(3);
		send_cmd(OP_UNUSED, bh, bl, 22'h3FFFFF, 32'hFFFF_FFFF);
		// fill every slot, with a duplicate token and a tie on creation time
		send_cmd(ste_pkg::OP_OPEN, ah, al, 22'h000000, 32'd100);
		send_cmd(ste_pkg::OP_OPEN, bh, bl, 22'h3FFFFF, 32'hFFFF_FFFF);
		send_cmd(ste_pkg::OP_OPEN, ch, cl, 22'h155555, 32'd50);
		gap(1);
		send_cmd(ste_pkg::OP_OPEN, ah, al, 22'h2AAAAA, 32'd50);
		for (int i = 0; i < 4; i++)
			send_cmd(ste_pkg::OP_OPEN, {$urandom, $urandom}, {$urandom, $urandom},
			         ste_pkg::USER_W'($urandom), 32'd200 + 32'd100 * i);
		// full: evict the lowest of the two oldest
		send_cmd(ste_pkg::OP_OPEN, {$urandom, $urandom}, {$urandom, $urandom},
		         ste_pkg::USER_W'($urandom), 32'd600);
		// idle exactly at the limit stays live, one past it expires
		send_cmd(ste_pkg::OP_CHECK, ah, al, 22'h0, 32'd100 + ste_pkg::TIMEOUT_RESET);
		gap(5);
		send_cmd(ste_pkg::OP_CHECK, ah, al, 22'h0, 32'd101 + 2 * ste_pkg::TIMEOUT_RESET);
		send_cmd(ste_pkg::OP_CHECK, ah, al, 22'h0, 32'd101 + 2 * ste_pkg::TIMEOUT_RESET);
		// idle time across the wrap of the clock
		send_cmd(ste_pkg::OP_CHECK, bh, bl, 22'h0, 32'h0000_0010);
		send_cmd(ste_pkg::OP_CLOSE, bh, bl, 22'h0, 32'h0000_0020);
		send_cmd(ste_pkg::OP_CLOSE, bh, bl, 22'h0, 32'h0000_0030);
		send_cmd(ste_pkg::OP_OPEN, ch ^ 64'h1, cl, 22'h3FFFFF, 32'd700);
		send_cmd(ste_pkg::OP_CHECK, ah, al ^ 64'h8000_0000_0000_0000, 22'h0, 32'd700);

		now_clock = 32'd1000;
		for (int p = 0; p < 8; p++) begin
			settle();
			write_timeout(phase_timeout[p]);
			for (int k = 0; k < PHASE_ITEMS; k++)
				random_cmd(p == 7);
		end

		settle();
		repeat (8) @(posedge clk);
		$display("Covered %0d commands over %0d timeout settings: ", n_sent, n_settings + 1,
		         "%0d opens (%0d evicting), %0d closes",
		         mirror.n_open, mirror.n_evict, mirror.n_close);
		$display("%0d live checks, %0d expiries, %0d misses; ",
		         mirror.n_live, mirror.n_expired, mirror.n_miss,
		         "%0d reply words, %0d mismatches", mirror.replies_seen, mirror.mismatches);
		if (mirror.mismatches == 0 && mirror.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

[session_table_with_expiry_top.f]
hw/rtl/ste_pkg.sv
hw/rtl/ste_slot_mem.sv
hw/rtl/session_table_with_expiry_top.sv
bench/tb.sv
